// File: src/pfsa_pkg.sv
// Shared types and constants for the free page stack allocator.
package pfsa_pkg;

  // Default sizing
  localparam int DEF_STACK_DEPTH = 8192;
  localparam int DEF_PAGE_BYTES  = 4096;

  // Input operation codes
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REGION = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Memory map entry that is walked
  localparam logic [31:0] LOAD_BASE   = 32'h0010_0000;
  localparam logic [31:0] USABLE_TYPE = 32'd1;

  // Configuration registers
  localparam int         CFG_IDX_W       = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADDRESS  = 1'd1;
  localparam logic [31:0] KERNEL_BYTES_RST = 32'h0000_0000;
  localparam logic [31:0] MAX_ADDRESS_RST  = 32'h2000_0000;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_kind_t;

  // addr: page to push on a free, first page of a region walk
  // lim:  end of the region walk (exclusive)
  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] addr;
    logic [31:0] lim;
  } cmd_t;

endpackage

// File: src/pfsa_front.sv
// Front end: accepts items and turns them into stack commands.
module pfsa_front import pfsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] free_addr,
  input  logic [31:0] region_type,
  input  logic [31:0] region_base,
  input  logic [31:0] region_length,
  input  logic [31:0] kernel_bytes,
  output logic        cmd_valid,
  input  logic        cmd_stall,
  output cmd_t        cmd
);

  logic loadable;
  logic accepted;

  assign loadable  = (region_type == USABLE_TYPE) && (region_base == LOAD_BASE);
  assign cmd_valid = in_valid;
  assign in_stall  = cmd_stall;
  assign accepted  = in_valid && !in_stall;

  always_comb begin
    cmd.kind = CMD_NOP;
    cmd.addr = free_addr;
    cmd.lim  = region_base + region_length;
    case (op)
      OP_ALLOC: begin
        cmd.kind = CMD_ALLOC;
      end
      OP_FREE: begin
        cmd.kind = CMD_FREE;
      end
      OP_REGION: begin
        // a region that is not usable RAM at the load base pushes nothing
        if (loadable) begin
          cmd.kind = CMD_LOAD;
          cmd.addr = region_base + kernel_bytes;
        end
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

  // a loadable region ends its walk at the fixed load base plus its length
  assert property (@(posedge clk) disable iff (rst)
    (accepted && cmd.kind == CMD_LOAD) |-> (cmd.lim == LOAD_BASE + region_length))
    else $error("region limit not formed from the load base");

  assert property (@(posedge clk) disable iff (rst)
    (accepted && cmd.kind == CMD_LOAD) |-> (op == OP_REGION))
    else $error("walk issued for an item that is not a region");

  assert property (@(posedge clk) disable iff (rst)
    (accepted && op == OP_FREE) |-> (cmd.kind == CMD_FREE && cmd.addr == free_addr))
    else $error("free lost its page address");

endmodule

// File: src/pfsa_cmdq.sv
// Short command queue that decouples the front end from the stack engine.
module pfsa_cmdq import pfsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_stall,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_stall,
  output cmd_t rd_cmd
);

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CMDQ_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(CMDQ_DEPTH - 1);

  cmd_t          entry [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_stall = (count == FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_cmd   = entry[rd_ptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("command queue count overran");

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("command queue lost a write");

  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("command queue pointers disagree while empty");

endmodule

// File: src/pfsa_back.sv
// Stack engine: holds the free page stack and carries out commands.
module pfsa_back import pfsa_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] max_address,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] page_out,
  output logic [1:0]  status,
  output logic [$clog2(STACK_DEPTH+1)-1:0] pages_added,
  output logic [31:0] total_pages
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [31:0]   PAGE_C  = 32'(PAGE_BYTES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_WALK = 3'b100
  } state_t;

  state_t        state;
  logic [31:0]   mem [STACK_DEPTH];
  logic [31:0]   mem_rd;
  logic [CW-1:0] stack_top;
  logic [31:0]   page_total;
  logic [31:0]   walk_addr;
  logic [31:0]   walk_end;
  logic [CW-1:0] added;

  logic          out_free;
  logic          cmd_take;
  logic          full;
  logic          empty;
  logic          walk_go;
  logic [CW-1:0] top_dec;
  logic          mem_we;
  logic [31:0]   mem_wd;
  logic          mem_re;

  assign out_free  = !out_valid || !out_stall;
  assign cmd_take  = (state == S_IDLE) && cmd_valid && out_free;
  assign cmd_stall = !((state == S_IDLE) && out_free);
  assign full      = (stack_top == DEPTH_C);
  assign empty     = (stack_top == '0);
  assign top_dec   = stack_top - CW'(1);
  assign walk_go   = (walk_addr < walk_end) && (walk_addr <= max_address);

  always_comb begin
    mem_we = 1'b0;
    mem_wd = cmd.addr;
    mem_re = 1'b0;
    if (cmd_take) begin
      mem_we = (cmd.kind == CMD_FREE) && !full;
      mem_re = (cmd.kind == CMD_ALLOC) && !empty;
    end else if (state == S_WALK) begin
      mem_we = walk_go && !full;
      mem_wd = walk_addr;
    end
  end

  // one write port at the top of stack, one registered read below it
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[stack_top[AW-1:0]] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd <= mem[top_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stack_top  <= '0;
      page_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_take) begin
            page_out    <= '0;
            status      <= ST_OK;
            pages_added <= '0;
            total_pages <= page_total;
            case (cmd.kind)
              CMD_ALLOC: begin
                if (empty) begin
                  out_valid <= 1'b1;
                  status    <= ST_EMPTY;
                end else begin
                  stack_top <= top_dec;
                  state     <= S_POP;
                end
              end
              CMD_FREE: begin
                out_valid <= 1'b1;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  stack_top <= stack_top + CW'(1);
                end
              end
              CMD_LOAD: begin
                walk_addr <= cmd.addr;
                walk_end  <= cmd.lim;
                added     <= '0;
                state     <= S_WALK;
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_POP: begin
          out_valid <= 1'b1;
          page_out  <= mem_rd;
          state     <= S_IDLE;
        end
        S_WALK: begin
          if (walk_go && !full) begin
            // push one page and advance
            stack_top  <= stack_top + CW'(1);
            walk_addr  <= walk_addr + PAGE_C;
            page_total <= page_total + 32'd1;
            added      <= added + CW'(1);
          end else begin
            out_valid   <= 1'b1;
            status      <= walk_go ? ST_FULL : ST_OK;
            pages_added <= added;
            total_pages <= page_total;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (out_valid && state == S_IDLE))
    else $error("pop did not deliver its result");

  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (stack_top < DEPTH_C))
    else $error("stack written beyond its depth");

  assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> (!out_valid || !out_stall))
    else $error("command taken while a result is still held");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && mem_we) |=> (page_total == $past(page_total) + 32'd1))
    else $error("page total missed a pushed page");

endmodule

// File: src/page_free_stack_allocator.sv
// Top level of the free page stack allocator.
// Keeps a stack of free physical page addresses in a single-port memory of
// STACK_DEPTH words. An allocate pops the top address (the stack engine
// registers the memory read, then moves it to page_out in S_POP); a free
// pushes an address; a usable region at the load base is walked one page
// per cycle until its end, max_address or a full stack. Items enter a
// two-entry command queue first, so input is taken while the engine works,
// and one result per item leaves in order through a result register. The
// stack memory needs no clearing after reset. The user writes kernel_bytes
// and max_address through the cfg port while the block is idle; the block
// itself does not enforce this.
module page_free_stack_allocator import pfsa_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           op,
  input  logic [31:0]          free_addr,
  input  logic [31:0]          region_type,
  input  logic [31:0]          region_base,
  input  logic [31:0]          region_length,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          page_out,
  output logic [1:0]           status,
  output logic [$clog2(STACK_DEPTH+1)-1:0] pages_added,
  output logic [31:0]          total_pages
);

  logic [31:0] kernel_bytes;
  logic [31:0] max_address;

  logic fq_valid;
  logic fq_stall;
  cmd_t fq_cmd;
  logic qb_valid;
  logic qb_stall;
  cmd_t qb_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_bytes <= KERNEL_BYTES_RST;
      max_address  <= MAX_ADDRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL_BYTES: kernel_bytes <= cfg_data;
        CFG_MAX_ADDRESS:  max_address  <= cfg_data;
        default: ;
      endcase
    end
  end

  pfsa_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .free_addr     (free_addr),
    .region_type   (region_type),
    .region_base   (region_base),
    .region_length (region_length),
    .kernel_bytes  (kernel_bytes),
    .cmd_valid     (fq_valid),
    .cmd_stall     (fq_stall),
    .cmd           (fq_cmd)
  );

  pfsa_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_stall (fq_stall),
    .wr_cmd   (fq_cmd),
    .rd_valid (qb_valid),
    .rd_stall (qb_stall),
    .rd_cmd   (qb_cmd)
  );

  pfsa_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .max_address (max_address),
    .cmd_valid   (qb_valid),
    .cmd_stall   (qb_stall),
    .cmd         (qb_cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .page_out    (page_out),
    .status      (status),
    .pages_added (pages_added),
    .total_pages (total_pages)
  );

endmodule
